/* rtl/aqat_pkg.sv */
// shared types, constants and tables of the quadrature angle tracker
package aqat_pkg;

	localparam int TABLE_ENTRIES = 257;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int PROD_W = 16 + IDX_W;
	localparam int CORDIC_W = 33;
	localparam int CORDIC_STEPS = 16;
	localparam int CENTRE_W = 14;

	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MAX_X = 2'd1;
	localparam logic [1:0] REG_MIN_Y = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TABLE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_INDEX,
		ST_RD_LO,
		ST_RD_HI,
		ST_MUL,
		ST_FIN,
		ST_ACC,
		ST_OUT
	} aqat_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} aqat_cordic_stat_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic [15:0] atan_step(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd8192;
			4'd1: r = 16'd4836;
			4'd2: r = 16'd2555;
			4'd3: r = 16'd1297;
			4'd4: r = 16'd651;
			4'd5: r = 16'd326;
			4'd6: r = 16'd163;
			4'd7: r = 16'd81;
			4'd8: r = 16'd41;
			4'd9: r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			4'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/aqat_cordic.sv */
// iterative vectoring cordic, one micro-rotation per cycle
module aqat_cordic import aqat_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [CENTRE_W-1:0]  num,
	input  logic signed [CENTRE_W-1:0]  den,
	output aqat_cordic_stat_t           stat,
	output logic signed [15:0]          angle
);

	logic signed [CORDIC_W-1:0] x_q, y_q, x0, y0, xs, ys;
	logic [15:0] z_q;
	logic [3:0] i_q;
	logic busy_q, done_q, zero_q;

	assign x0 = CORDIC_W'(den) <<< 16;
	assign y0 = CORDIC_W'(num) <<< 16;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (num == '0) && (den == '0);
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 16'h8000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_step(i_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_step(i_q);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign angle = zero_q ? 16'sd0 : signed'(z_q);

endmodule

/* rtl/analog_quadrature_angle_tracker.sv */
// top level of the sine/cosine encoder angle tracker
// usage:
// - input channel (in_valid/in_ready) takes one word: cmd selects a sample pair
//   (sample_x, sample_y) or a calibration write (entry_index, entry_angle)
// - a calibration write lands in the table at acceptance and gives no result
// - a sample word gives one result word on the output channel (out_valid/out_ready):
//   aligned_angle, angle_step and the wrapping multi-turn total_angle
// - one word is worked on at a time; in_ready is high only while idle
// - to reach out_valid a sample passes 16 cordic steps, index and two table reads,
//   a bit-serial interpolation multiply and a nibble-serial accumulate of the total
// - the result sits in an output register; while the receiver stalls the block
//   is idle again and takes the next word, and only holds at its end if the
//   previous result has still not gone
// - configuration (cfg_we, cfg_index, cfg_data) is to be written only while idle;
//   the user keeps to this, the block itself does not enforce it
// - reset restores the min/max registers, clears the total and marks the next
//   sample as the first (step 0); the calibration table is not cleared and must
//   be written before use
module analog_quadrature_angle_tracker import aqat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [11:0]        sample_x,
	input  logic [11:0]        sample_y,
	input  logic [8:0]         entry_index,
	input  logic signed [15:0] entry_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] aligned_angle,
	output logic signed [15:0] angle_step,
	output logic signed [31:0] total_angle
);

	aqat_state_t state_q, state_d;

	// configuration registers
	logic [11:0] min_x_q, max_x_q, min_y_q, max_y_q;

	// calibration table, undefined until written
	logic signed [15:0] table_mem [TABLE_ENTRIES];
	logic signed [15:0] rd_data_q, lo_q;
	logic [IDX_W-1:0] idx_q, rd_addr;

	logic in_acc, smp_acc, tbl_acc;
	logic cordic_start;
	aqat_cordic_stat_t cordic_stat;
	logic signed [15:0] raw_angle;

	logic signed [CENTRE_W-1:0] cx, cy;
	logic signed [12:0] span_x, span_y;

	logic [15:0] uang;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0] idx_raw;
	logic [15:0] frac_q;
	logic signed [16:0] diff_q;
	logic signed [17:0] mac_q;
	logic signed [18:0] mac_sum;
	logic [4:0] cnt_q;

	logic signed [15:0] aligned, prev_q, aligned_q;
	logic signed [16:0] step_raw, step_fix, step_q;
	logic first_q;

	logic [31:0] tot_q, dsh_q;
	logic carry_q;
	logic [4:0] nib_sum;
	logic out_load;

	assign in_acc  = in_valid && in_ready;
	assign smp_acc = in_acc && (cmd == CMD_SAMPLE);
	assign tbl_acc = in_acc && (cmd == CMD_TABLE);

	// centring on the midpoint, half span truncated toward zero
	assign span_x = 13'(signed'({1'b0, max_x_q})) - 13'(signed'({1'b0, min_x_q}));
	assign span_y = 13'(signed'({1'b0, max_y_q})) - 13'(signed'({1'b0, min_y_q}));
	assign cx = CENTRE_W'(signed'({1'b0, sample_x})) - CENTRE_W'(signed'({1'b0, min_x_q}))
		- CENTRE_W'((span_x + signed'({12'd0, span_x[12]})) >>> 1);
	assign cy = CENTRE_W'(signed'({1'b0, sample_y})) - CENTRE_W'(signed'({1'b0, min_y_q}))
		- CENTRE_W'((span_y + signed'({12'd0, span_y[12]})) >>> 1);

	// atan2(x, y): x is the numerator
	aqat_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.num    (cx),
		.den    (cy),
		.stat   (cordic_stat),
		.angle  (raw_angle)
	);

	// table index and fraction from the offset angle
	assign uang = raw_angle ^ 16'h8000;
	assign prod = PROD_W'(uang) * PROD_W'(TABLE_ENTRIES - 1);
	assign idx_raw = (32'(prod[PROD_W-1:16]) >= 32'(TABLE_ENTRIES - 1))
		? IDX_W'(TABLE_ENTRIES - 2) : prod[PROD_W-1:16];

	// shift-and-add multiply, one fraction bit per cycle, floor kept by the shifts
	assign mac_sum = 19'(mac_q) + (frac_q[0] ? 19'(diff_q) : 19'sd0);

	// unwrap of the step into [-pi, pi]
	assign aligned  = lo_q + mac_q[15:0];
	assign step_raw = first_q ? 17'sd0 : (17'(aligned) - 17'(prev_q));
	always_comb begin
		step_fix = step_raw;
		if (step_raw < -17'sd32768)
			step_fix = step_raw + 17'sd65536;
		else if (step_raw > 17'sd32768)
			step_fix = step_raw - 17'sd65536;
	end

	// nibble-serial add of the step into the total
	assign nib_sum = {1'b0, tot_q[3:0]} + {1'b0, dsh_q[3:0]} + {4'd0, carry_q};

	assign rd_addr = (state_q == ST_RD_HI) ? idx_q + IDX_W'(1) : idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (smp_acc) state_d = ST_CORDIC;
			ST_CORDIC: if (cordic_stat.done) state_d = ST_INDEX;
			ST_INDEX:  state_d = ST_RD_LO;
			ST_RD_LO:  state_d = ST_RD_HI;
			ST_RD_HI:  state_d = ST_MUL;
			ST_MUL:    if (cnt_q == 5'd16) state_d = ST_FIN;
			ST_FIN:    state_d = ST_ACC;
			ST_ACC:    if (cnt_q == 5'd7) state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		cordic_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cordic_start = smp_acc;
			end
			ST_OUT:  out_load = !out_valid || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_x_q <= 12'd0;
			max_x_q <= 12'd4095;
			min_y_q <= 12'd0;
			max_y_q <= 12'd4095;
			prev_q <= '0;
			tot_q <= '0;
			first_q <= 1'b1;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_X: min_x_q <= cfg_data;
					REG_MAX_X: max_x_q <= cfg_data;
					REG_MIN_Y: min_y_q <= cfg_data;
					REG_MAX_Y: max_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_MUL || state_q == ST_ACC)
				cnt_q <= (state_d == state_q) ? cnt_q + 5'd1 : '0;
			else
				cnt_q <= '0;
			if (state_q == ST_FIN) begin
				prev_q <= aligned;
				first_q <= 1'b0;
			end
			if (state_q == ST_ACC)
				tot_q <= {nib_sum[3:0], tot_q[31:4]};
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// table port and datapath registers
	always_ff @(posedge clk) begin
		if (tbl_acc && (32'(entry_index) < 32'(TABLE_ENTRIES)))
			table_mem[IDX_W'(entry_index)] <= entry_angle;
		rd_data_q <= table_mem[rd_addr];
		case (state_q)
			ST_INDEX: begin
				idx_q <= idx_raw;
				frac_q <= prod[15:0];
			end
			ST_RD_HI: begin
				lo_q <= rd_data_q;
				mac_q <= '0;
			end
			ST_MUL: begin
				if (cnt_q == 5'd0)
					diff_q <= 17'(rd_data_q) - 17'(lo_q);
				else begin
					mac_q <= mac_sum[18:1];
					frac_q <= {1'b0, frac_q[15:1]};
				end
			end
			ST_FIN: begin
				aligned_q <= aligned;
				step_q <= step_fix;
				dsh_q <= 32'(step_fix);
				carry_q <= 1'b0;
			end
			ST_ACC: begin
				dsh_q <= {4'd0, dsh_q[31:4]};
				carry_q <= nib_sum[4];
			end
			default: ;
		endcase
		if (out_load) begin
			aligned_angle <= aligned_q;
			angle_step <= step_q[15:0];
			total_angle <= tot_q;
		end
	end

`ifndef SYNTHESIS
	a_start_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> state_q == ST_CORDIC && cordic_stat.busy)
		else $error("sample word did not start the cordic");
	a_done_in_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_stat.done |-> state_q == ST_CORDIC)
		else $error("cordic finished outside its state");
	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !first_q)
		else $error("result shown before the first-sample flag cleared");
`endif

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the sine/cosine encoder angle tracker
module tb_top;
	import aqat_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 100;   // wait after the last result is back
	localparam int STALL_LIMIT  = 5000;  // cycles in which neither channel moves a word
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off

	// one input word as it is offered on the input channel
	typedef struct {
		logic               cmd;
		logic [11:0]        x;
		logic [11:0]        y;
		logic [8:0]         idx;
		logic signed [15:0] ang;
	} tracker_word_t;

	// one expected result word
	typedef struct {
		logic signed [15:0] aligned;
		logic signed [15:0] step;
		logic signed [31:0] total;
	} tracker_result_t;

	// predicts the tracker from its own copy of registers, table and running state,
	// and checks each result word against the oldest prediction
	class angle_scoreboard;
		logic [11:0]        lim_min_x, lim_max_x, lim_min_y, lim_max_y;
		logic signed [15:0] cal[TABLE_ENTRIES];
		logic signed [15:0] last_angle;
		logic signed [31:0] turn_total;
		bit                 first_pending;
		tracker_result_t    awaited[$];
		int                 errors;

		function new();
			lim_min_x = 12'd0;
			lim_max_x = 12'd4095;
			lim_min_y = 12'd0;
			lim_max_y = 12'd4095;
			foreach (cal[i]) cal[i] = '0;
			last_angle = '0;
			turn_total = '0;
			first_pending = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [11:0] data);
			case (idx)
				REG_MIN_X: lim_min_x = data;
				REG_MAX_X: lim_max_x = data;
				REG_MIN_Y: lim_min_y = data;
				default:   lim_max_y = data;
			endcase
		endfunction

		// reading minus the midpoint of its range, halving toward zero
		function int centred(logic [11:0] s, logic [11:0] lo, logic [11:0] hi);
			int span;
			span = int'(hi) - int'(lo);
			return int'(s) - (int'(lo) + span / 2);
		endfunction

		// 16-step cordic vectoring, binary angle of (den, num)
		function logic signed [15:0] vector_angle(int num, int den);
			longint xa, ya, xs, ys;
			logic [31:0] z;
			if (num == 0 && den == 0)
				return '0;
			xa = longint'(den) * 65536;
			ya = longint'(num) * 65536;
			z = 0;
			if (xa < 0) begin
				xa = -xa;
				ya = -ya;
				z = 32768;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = xa >>> i;
				ys = ya >>> i;
				if (ya >= 0) begin
					xa += ys;
					ya -= xs;
					z += atan_steps_of(i);
				end else begin
					xa -= ys;
					ya += xs;
					z -= atan_steps_of(i);
				end
			end
			return z[15:0];
		endfunction

		function int atan_steps_of(int i);
			int lut[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
				41, 20, 10, 5, 3, 1, 1, 0};
			return lut[i];
		endfunction

		// calibration lookup with linear interpolation between neighbours
		function logic signed [15:0] calibrated(logic signed [15:0] a);
			longint u, p, frac, lo, hi, r;
			int k;
			u = longint'(a) + 32768;
			p = u * (TABLE_ENTRIES - 1);
			k = int'(p >> 16);
			frac = p & 64'hFFFF;
			if (k + 1 >= TABLE_ENTRIES)
				k = TABLE_ENTRIES - 2;
			lo = cal[k];
			hi = cal[k + 1];
			r = lo + (((hi - lo) * frac) >>> 16);
			return r[15:0];
		endfunction

		function void note_word(tracker_word_t w);
			tracker_result_t res;
			logic signed [15:0] al;
			int d;
			if (w.cmd == CMD_TABLE) begin
				if (int'(w.idx) < TABLE_ENTRIES)
					cal[w.idx] = w.ang;
				return;
			end
			al = calibrated(vector_angle(centred(w.x, lim_min_x, lim_max_x),
				centred(w.y, lim_min_y, lim_max_y)));
			if (first_pending) begin
				last_angle = al;
				first_pending = 1'b0;
			end
			d = int'(al) - int'(last_angle);
			last_angle = al;
			if (d < -32768)
				d += 65536;
			if (d > 32768)
				d -= 65536;
			turn_total += d;
			res.aligned = al;
			res.step = d[15:0];
			res.total = turn_total;
			awaited.push_back(res);
		endfunction

		function void check_result(logic signed [15:0] al, logic signed [15:0] st,
				logic signed [31:0] tot);
			tracker_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: result with none awaited: aligned %0d step %0d total %0d",
					$time, al, st, tot);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (al !== e.aligned) begin
				$display("%0t: aligned_angle expected %0d actual %0d", $time, e.aligned, al);
				errors++;
			end
			if (st !== e.step) begin
				$display("%0t: angle_step expected %0d actual %0d", $time, e.step, st);
				errors++;
			end
			if (tot !== e.total) begin
				$display("%0t: total_angle expected %0d actual %0d", $time, e.total, tot);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = CMD_SAMPLE;
	logic [11:0]        sample_x = '0;
	logic [11:0]        sample_y = '0;
	logic [8:0]         entry_index = '0;
	logic signed [15:0] entry_angle = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] aligned_angle;
	logic signed [15:0] angle_step;
	logic signed [31:0] total_angle;

	angle_scoreboard sb = new();

	int send_idle_pct = 0;   // chance of a gap after each input word
	int recv_stall_pct = 0;  // chance of out_ready low in a cycle
	int hold_left = 0;       // receiver hold-off, counted down by the receiver
	int quiet_cycles = 0;

	analog_quadrature_angle_tracker dut (.*);

	always #5 clk = ~clk;

	// receiver: random stalls, plus the long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result words are checked as they leave
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(aligned_angle, angle_step, total_angle);
	end

	// watchdog over cycles in which neither channel moves a word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL analog_quadrature_angle_tracker");
			$finish;
		end
	end

	// offer one word and hold it until accepted, then maybe leave a gap
	task automatic send_word(tracker_word_t w);
		in_valid <= 1'b1;
		cmd <= w.cmd;
		sample_x <= w.x;
		sample_y <= w.y;
		entry_index <= w.idx;
		entry_angle <= w.ang;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_sample(logic [11:0] x, logic [11:0] y);
		tracker_word_t w;
		w.cmd = CMD_SAMPLE;
		w.x = x;
		w.y = y;
		w.idx = 9'($urandom);
		w.ang = 16'($urandom);
		send_word(w);
	endtask

	task automatic send_entry(logic [8:0] idx, logic signed [15:0] ang);
		tracker_word_t w;
		w.cmd = CMD_TABLE;
		w.x = 12'($urandom);
		w.y = 12'($urandom);
		w.idx = idx;
		w.ang = ang;
		send_word(w);
	endtask

	// sender stops until every result is back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(logic [11:0] mnx, logic [11:0] mxx,
			logic [11:0] mny, logic [11:0] mxy);
		write_reg(REG_MIN_X, mnx);
		write_reg(REG_MAX_X, mxx);
		write_reg(REG_MIN_Y, mny);
		write_reg(REG_MAX_Y, mxy);
	endtask

	// mostly samples, some table rewrites including indexes past the table
	task automatic random_words(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 12)
				send_entry(9'($urandom), 16'($urandom));
			else if (r < 20)
				send_sample(12'($urandom_range(4095) & 12'hF00 | 12'h0FF),
					12'($urandom_range(4095) & 12'hF00));
			else
				send_sample(12'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole table first: a plain ramp, every entry written before any sample
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_entry(9'(i), 16'((i - 128) * 256));
		send_entry(9'd0, -16'sd32768);
		send_entry(9'd256, 16'sd32767);
		send_entry(9'd257, 16'sd1234);   // past the table, ignored
		send_entry(9'd511, -16'sd1);

		// both readings at the midpoint read entry 128 alone: force steps of pi
		send_sample(12'd2047, 12'd2047);
		send_entry(9'd128, -16'sd32768);
		send_sample(12'd2047, 12'd2047);
		send_entry(9'd128, 16'sd0);
		send_sample(12'd2047, 12'd2047);  // exactly +pi
		send_entry(9'd128, -16'sd32768);
		send_sample(12'd2047, 12'd2047);  // exactly -pi
		send_entry(9'd128, 16'sd0);
		// reading extremes and each axis
		send_sample(12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd4095, 12'd0);
		send_sample(12'd2047, 12'd0);
		send_sample(12'd2047, 12'd4095);
		send_sample(12'd0, 12'd2047);
		send_sample(12'd4095, 12'd2047);
		drain();

		// phase 1: no idling, long receiver hold-off to fill the block
		hold_left = HOLD_CYCLES;
		random_words(300);
		drain();

		// phase 2: sender idles, odd limits with min above max
		set_limits(12'd4095, 12'd0, 12'd3000, 12'd100);
		send_idle_pct = 46;
		random_words(300);
		drain();

		// phase 3: receiver stalls, collapsed ranges
		set_limits(12'd0, 12'd0, 12'd4095, 12'd4095);
		send_idle_pct = 0;
		recv_stall_pct = 46;
		random_words(250);
		drain();

		// phase 4: both idle, random limits
		set_limits(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
		send_idle_pct = 37;
		recv_stall_pct = 37;
		random_words(300);
		drain();

		// back to the reset limits, no idling
		set_limits(12'd0, 12'd4095, 12'd0, 12'd4095);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_words(100);
		drain();

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS analog_quadrature_angle_tracker");
		else
			$display("FAIL analog_quadrature_angle_tracker");
		$finish;
	end

endmodule

/* filelist.f */
rtl/aqat_pkg.sv
rtl/aqat_cordic.sv
rtl/analog_quadrature_angle_tracker.sv
tb/tb_top.sv
